FILE: sv/epd_pkg.sv
`default_nettype none
package epd_pkg;

  localparam int unsigned DriveMaxDefault = 400;
  localparam int unsigned MagW = 16;
  localparam int unsigned AddrW = 4;

  localparam logic [1:0] FUNC_EDGE_A = 2'd0;
  localparam logic [1:0] FUNC_EDGE_B = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] REG_KP   = 2'd0;
  localparam logic [1:0] REG_KD   = 2'd1;
  localparam logic [1:0] REG_BAND = 2'd2;

  typedef struct packed {
    logic               tick;
    logic               settled;
    logic [31:0]        position;
    logic signed [31:0] err;
    logic signed [31:0] dlt;
  } epd_track_t;

  typedef struct packed {
    logic               tick;
    logic               settled;
    logic [31:0]        position;
    logic signed [63:0] sum;
  } epd_sum_t;

endpackage
`default_nettype wire

FILE: sv/encoder_pd_position_drive.sv
// throughput: one transaction per cycle while out_ready is high,
// four registered stages (count, products, sum, drive)
// each stage holds its data while the next is stalled, so input is taken whenever stage one frees
// reset (rst_n low, synchronous): count and sample cleared, gains and band to defaults,
// drive 0, direction 0, brake on, pipeline empty
`default_nettype none
module encoder_pd_position_drive
  import epd_pkg::*;
#(
  parameter int unsigned DRIVE_MAX = DriveMaxDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic               in_enc_a,
  input  wire logic               in_enc_b,
  input  wire logic signed [15:0] in_target_position,
  input  wire logic               in_start_move,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_position,
  output logic [8:0]              out_drive_level,
  output logic                    out_clockwise,
  output logic                    out_brake,
  output logic                    out_settled
);

  logic signed [31:0] kp_r, kd_r;
  logic [15:0]        band_r;
  logic [1:0]         reg_idx;
  logic               wr_en;

  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_b, rdy_c, rdy_d;
  logic ld_a, ld_b, ld_c, ld_d;

  epd_track_t trk;
  epd_sum_t   sm;
  logic [31:0] pos;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= 32'sd65536;
      kd_r   <= 32'sd0;
      band_r <= 16'd10;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KP:   kp_r   <= pwdata;
        REG_KD:   kd_r   <= pwdata;
        REG_BAND: band_r <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KP:   prdata = kp_r;
      REG_KD:   prdata = kd_r;
      REG_BAND: prdata = {16'b0, band_r};
      default:  prdata = '0;
    endcase
  end

  // per-stage flow control
  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign in_ready = !va_r || rdy_b;

  assign ld_a = in_valid && in_ready;
  assign ld_b = va_r && rdy_b;
  assign ld_c = vb_r && rdy_c;
  assign ld_d = vc_r && rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_d) begin
        vd_r <= vc_r;
      end
    end
  end

  epd_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (ld_a),
    .func            (in_func),
    .enc_a           (in_enc_a),
    .enc_b           (in_enc_b),
    .target_position (in_target_position),
    .start_move      (in_start_move),
    .band            (band_r),
    .trk_r           (trk)
  );

  epd_mult u_mult (
    .clk       (clk),
    .load_prod (ld_b),
    .load_sum  (ld_c),
    .trk       (trk),
    .kp        (kp_r),
    .kd        (kd_r),
    .sum_r     (sm)
  );

  epd_drive #(
    .DRIVE_MAX (DRIVE_MAX)
  ) u_drive (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (ld_d),
    .sm           (sm),
    .position_r   (pos),
    .drive_hold_r (out_drive_level),
    .dir_hold_r   (out_clockwise),
    .brake_hold_r (out_brake),
    .settled_r    (out_settled)
  );

  assign out_valid    = vd_r;
  assign out_position = pos;

`ifndef ASSERT_OFF
  a_settled_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_settled |-> out_brake)
    else $error("settled result without brake");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_CLEAR |=> trk.position == 32'd0)
    else $error("clear transaction left nonzero count");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> va_r && vb_r && vc_r && vd_r)
    else $error("input stalled with a free stage");
`endif

endmodule
`default_nettype wire

FILE: sv/epd_track.sv
`default_nettype none
module epd_track
  import epd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [1:0]        func,
  input  wire logic              enc_a,
  input  wire logic              enc_b,
  input  wire logic signed [15:0] target_position,
  input  wire logic              start_move,
  input  wire logic [15:0]       band,
  output epd_track_t             trk_r
);

  logic [31:0]        count_r, count_nxt;
  logic [31:0]        prev_r;
  logic [31:0]        prev_eff;
  logic signed [32:0] err, dlt, err_mag;
  logic               settled;
  epd_track_t         trk_nxt;

  function automatic logic signed [31:0] clamp31(logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0001 : 32'sh7FFF_FFFF;
    end else if (v[31:0] == 32'h8000_0000) begin
      r = 32'sh8000_0001;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign prev_eff = start_move ? count_r : prev_r;
  assign err      = $signed({{17{target_position[15]}}, target_position})
                  - $signed({count_r[31], count_r});
  assign dlt      = $signed({count_r[31], count_r}) - $signed({prev_eff[31], prev_eff});
  assign err_mag  = err[32] ? -err : err;
  assign settled  = (err_mag <= $signed({17'b0, band}));

  always_comb begin
    case (func)
      FUNC_EDGE_A: count_nxt = (enc_a == enc_b) ? count_r - 32'd1 : count_r + 32'd1;
      FUNC_EDGE_B: count_nxt = (enc_a == enc_b) ? count_r + 32'd1 : count_r - 32'd1;
      FUNC_CLEAR:  count_nxt = '0;
      default:     count_nxt = count_r;
    endcase
  end

  always_comb begin
    trk_nxt.tick     = (func == FUNC_TICK);
    trk_nxt.settled  = (func == FUNC_TICK) && settled;
    trk_nxt.position = count_nxt;
    trk_nxt.err      = clamp31(err);
    trk_nxt.dlt      = clamp31(dlt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= '0;
    end else if (load) begin
      count_r <= count_nxt;
      if (func == FUNC_TICK) begin
        prev_r <= count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trk_r <= trk_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/epd_mult.sv
`default_nettype none
module epd_mult
  import epd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load_prod,
  input  wire logic               load_sum,
  input  wire epd_track_t         trk,
  input  wire logic signed [31:0] kp,
  input  wire logic signed [31:0] kd,
  output epd_sum_t                sum_r
);

  logic               tick_r, settled_r;
  logic [31:0]        position_r;
  logic signed [63:0] pe_r, pd_r;
  logic signed [63:0] pe_nxt, pd_nxt;

  assign pe_nxt = trk.err * kp;
  assign pd_nxt = trk.dlt * kd;

  // product stage
  always_ff @(posedge clk) begin
    if (load_prod) begin
      tick_r     <= trk.tick;
      settled_r  <= trk.settled;
      position_r <= trk.position;
      pe_r       <= pe_nxt;
      pd_r       <= pd_nxt;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (load_sum) begin
      sum_r.tick     <= tick_r;
      sum_r.settled  <= settled_r;
      sum_r.position <= position_r;
      sum_r.sum      <= pe_r + pd_r;
    end
  end

endmodule
`default_nettype wire

FILE: sv/epd_drive.sv
`default_nettype none
module epd_drive
  import epd_pkg::*;
#(
  parameter int unsigned DRIVE_MAX = DriveMaxDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire epd_sum_t    sm,
  output logic [31:0]      position_r,
  output logic [8:0]       drive_hold_r,
  output logic             dir_hold_r,
  output logic             brake_hold_r,
  output logic             settled_r
);

  localparam logic signed [47:0] DMax    = 48'(DRIVE_MAX);
  localparam logic signed [47:0] DMaxNeg = -DMax;
  localparam logic [MagW-1:0]    DMaxMag = MagW'(DRIVE_MAX);

  logic signed [63:0] biased;
  logic signed [47:0] drive;
  logic [MagW-1:0]    dlo, mag;
  logic               neg;

  // truncate toward zero
  assign biased = sm.sum + (sm.sum[63] ? 64'sd65535 : 64'sd0);
  assign drive  = biased[63:16];
  assign neg    = drive[47];
  assign dlo    = drive[MagW-1:0];

  always_comb begin
    if (drive >= DMax || drive <= DMaxNeg) begin
      mag = DMaxMag;
    end else if (neg) begin
      mag = ~dlo + MagW'(1);
    end else begin
      mag = dlo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_hold_r <= '0;
      dir_hold_r   <= 1'b0;
      brake_hold_r <= 1'b1;
    end else if (load && sm.tick) begin
      if (sm.settled) begin
        brake_hold_r <= 1'b1;
      end else begin
        drive_hold_r <= mag[8:0];
        dir_hold_r   <= neg;
        brake_hold_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      position_r <= sm.position;
      settled_r  <= sm.settled;
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import epd_pkg::*;

  localparam int Latency = 4;
  localparam int IdleLimit = 2000;
  localparam int PhaseItems = 120;
  localparam longint Lim31 = 64'sd2147483647;

  typedef struct packed {
    logic [1:0]  func;
    logic        enc_a;
    logic        enc_b;
    logic [15:0] target_position;
    logic        start_move;
  } item_t;

  typedef struct packed {
    logic [31:0] position;
    logic [8:0]  drive_level;
    logic        clockwise;
    logic        brake;
    logic        settled;
  } report_t;

  class pd_scoreboard;
    logic [31:0] kp;
    logic [31:0] kd;
    logic [15:0] band;
    logic [31:0] count;
    logic [31:0] sample;
    logic [8:0]  level_hold;
    logic        cw_hold;
    logic        brake_hold;
    report_t     pending_reports[$];
    int          failures;
    int          checked;
    int          ticks;
    int          settles;

    function new();
      kp = 32'd65536;
      kd = '0;
      band = 16'd10;
      count = '0;
      sample = '0;
      level_hold = '0;
      cw_hold = 1'b0;
      brake_hold = 1'b1;
      failures = 0;
      checked = 0;
      ticks = 0;
      settles = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_KP: kp = val;
        REG_KD: kd = val;
        REG_BAND: band = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sat31(longint v);
      if (v > Lim31) return Lim31;
      if (v < -Lim31) return -Lim31;
      return v;
    endfunction

    // advance count and drive state for one accepted transaction
    function void note_item(item_t it);
      report_t r;
      longint  pos;
      longint  err;
      longint  mag;
      longint  sum;
      longint  drv;
      logic    settled;
      settled = 1'b0;
      case (it.func)
        FUNC_EDGE_A: count = (it.enc_a == it.enc_b) ? count - 1 : count + 1;
        FUNC_EDGE_B: count = (it.enc_a == it.enc_b) ? count + 1 : count - 1;
        FUNC_CLEAR: count = '0;
        default: begin
          ticks++;
          if (it.start_move) sample = count;
          pos = longint'($signed(count));
          err = longint'($signed(it.target_position)) - pos;
          mag = (err < 0) ? -err : err;
          if (mag <= longint'(band)) begin
            brake_hold = 1'b1;
            settled = 1'b1;
            settles++;
          end else begin
            sum = sat31(err) * longint'($signed(kp))
                + sat31(pos - longint'($signed(sample))) * longint'($signed(kd));
            drv = sum / 65536;
            mag = (drv < 0) ? -drv : drv;
            if (mag > longint'(DriveMaxDefault)) mag = longint'(DriveMaxDefault);
            cw_hold = (drv < 0);
            level_hold = mag[8:0];
            brake_hold = 1'b0;
          end
          sample = count;
        end
      endcase
      r.position = count;
      r.drive_level = level_hold;
      r.clockwise = cw_hold;
      r.brake = brake_hold;
      r.settled = settled;
      pending_reports.push_back(r);
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result transaction with nothing pending, pos=%0d", $realtime,
                   $signed(got.position));
        return;
      end
      want = pending_reports.pop_front();
      checked++;
      if (got.position !== want.position || got.drive_level !== want.drive_level ||
          got.clockwise !== want.clockwise || got.brake !== want.brake ||
          got.settled !== want.settled) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch expected pos=%0d lvl=%0d cw=%b brk=%b set=%b", $realtime,
                   $signed(want.position), want.drive_level, want.clockwise, want.brake,
                   want.settled);
          $display("           actual pos=%0d lvl=%0d cw=%b brk=%b set=%b",
                   $signed(got.position), got.drive_level, got.clockwise, got.brake,
                   got.settled);
        end
      end
    endfunction

    function void close_out();
      if (pending_reports.size() != 0) begin
        failures += pending_reports.size();
        $display("%0d expected results never arrived", pending_reports.size());
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_EDGE_A;
  logic               in_enc_a = 1'b0;
  logic               in_enc_b = 1'b0;
  logic signed [15:0] in_target_position = '0;
  logic               in_start_move = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_position;
  logic [8:0]         out_drive_level;
  logic               out_clockwise;
  logic               out_brake;
  logic               out_settled;

  pd_scoreboard sb;
  int burst_left = 0;
  int sent = 0;
  int reg_writes = 0;
  int settings = 1;
  logic qa = 1'b0;
  logic qb = 1'b0;
  logic walk_up = 1'b1;

  encoder_pd_position_drive DUT (.*);

  always #4 clk = ~clk;

  // receiver stall pattern
  int rx_left = 0;
  int rx_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(report_t'{out_position, out_drive_level, out_clockwise, out_brake,
                                out_settled});
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= 300;
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (rx_left[1:0] != 2'd0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("no transaction for %0d cycles", IdleLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t mk(logic [1:0] f, logic a, logic b, logic [15:0] tgt, logic st);
    item_t it;
    it.func = f;
    it.enc_a = a;
    it.enc_b = b;
    it.target_position = tgt;
    it.start_move = st;
    return it;
  endfunction

  // mostly clean quadrature walks and ticks near the count, some noise
  function automatic item_t next_item();
    item_t it;
    int    pick;
    int    off;
    it = mk(FUNC_TICK, qa, qb, 16'($urandom), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) walk_up = !walk_up;
    if (pick < 60) begin
      if ((qa == qb) == walk_up) begin
        qa = !qa;
        it.func = FUNC_EDGE_A;
      end else begin
        qb = !qb;
        it.func = FUNC_EDGE_B;
      end
      it.enc_a = qa;
      it.enc_b = qb;
    end else if (pick < 85) begin
      it.start_move = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0) begin
        off = $urandom_range(0, 120);
        off = off - 60;
        it.target_position = 16'($signed(sb.count) + off);
      end
    end else if (pick < 90) begin
      it.func = FUNC_CLEAR;
    end else begin
      it.func = 2'($urandom_range(0, 3));
      it.enc_a = 1'($urandom_range(0, 1));
      it.enc_b = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    in_valid <= 1'b1;
    in_func <= it.func;
    in_enc_a <= it.enc_a;
    in_enc_b <= it.enc_b;
    in_target_position <= it.target_position;
    in_start_move <= it.start_move;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
  endtask

  task automatic run_phase(input logic [31:0] kp, input logic [31:0] kd,
                           input logic [15:0] band);
    drain();
    reg_write(REG_KP, kp);
    reg_write(REG_KD, kd);
    reg_write(REG_BAND, {16'd0, band});
    settings++;
    repeat (PhaseItems) send_item(next_item());
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: drive equals error, band of ten
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, 16'd0, 1'b1));
    send_item(mk(FUNC_EDGE_A, 1'b0, 1'b0, 16'h8000, 1'b1));
    send_item(mk(FUNC_EDGE_A, 1'b1, 1'b0, 16'h7fff, 1'b0));
    send_item(mk(FUNC_EDGE_A, 1'b0, 1'b1, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_A, 1'b1, 1'b1, 16'hffff, 1'b1));
    send_item(mk(FUNC_EDGE_B, 1'b0, 1'b0, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_B, 1'b1, 1'b0, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_B, 1'b0, 1'b1, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_B, 1'b1, 1'b1, 16'd0, 1'b0));
    send_item(mk(FUNC_TICK, 1'b1, 1'b1, 16'h7fff, 1'b1));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, 16'h8000, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, 16'd10, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, 16'd11, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, -16'sd10, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, -16'sd11, 1'b1));
    send_item(mk(FUNC_EDGE_A, 1'b1, 1'b0, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_B, 1'b1, 1'b1, 16'd0, 1'b0));
    send_item(mk(FUNC_EDGE_A, 1'b0, 1'b1, 16'd0, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b1, 16'd3, 1'b0));
    send_item(mk(FUNC_TICK, 1'b0, 1'b1, 16'd14, 1'b0));
    send_item(mk(FUNC_CLEAR, 1'b1, 1'b1, 16'hffff, 1'b1));
    send_item(mk(FUNC_TICK, 1'b0, 1'b0, 16'd0, 1'b0));

    repeat (130) send_item(next_item());
    run_phase($urandom_range(4096, 1 << 20), 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
              16'($urandom_range(0, 20)));
    run_phase(32'h7fff_ffff, 32'h8000_0000, 16'd0);
    run_phase(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    run_phase(32'($urandom_range(1, 255)), 32'($urandom_range(0, 255)), 16'd1);
    run_phase($urandom, $urandom, 16'($urandom_range(0, 50)));
    run_phase(-32'($urandom_range(1 << 14, 1 << 18)), 32'($urandom_range(1 << 14, 1 << 18)),
              16'd3);

    drain();
    repeat (4 * Latency) @(posedge clk);
    sb.close_out();
    $display("covered %0d input transactions, %0d results checked, %0d ticks (%0d settled)",
             sent, sb.checked, sb.ticks, sb.settles);
    $display("%0d register writes across %0d gain and band settings, %0d errors",
             reg_writes, settings, sb.failures);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
